// ===== hdl/abam_pkg.sv =====
`timescale 1ns / 1ps

package abam_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int OUT_W        = 8;
    localparam int MV_W         = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;
    localparam int DIV_W        = 22;
    localparam int DIVISOR_W    = 12;
    localparam int MV_FULL_SCALE = 3300;
    localparam int ADC_SHIFT    = 12;
    localparam int BASE_NEUTRAL = 127;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
    } abam_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] brightness;
        logic [MV_W-1:0]  average_mv;
    } abam_rsp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK   = 3'd0,
        CFG_BRIGHT = 3'd1,
        CFG_MIN    = 3'd2,
        CFG_MAX    = 3'd3,
        CFG_BASE   = 3'd4
    } cfg_idx_t;

    localparam logic ACTION_PRIME = 1'b0;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_UPDATE,
        UOP_DIV_AVG,
        UOP_MV,
        UOP_MAP_PREP,
        UOP_DIV_MAP,
        UOP_FINISH,
        UOP_PRIME
    } uop_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_PRIME,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic item_taken;
        logic prime;
        logic div_busy;
        logic out_busy;
    } abam_status_t;

    typedef struct packed {
        uop_t op;
        logic fire;
    } abam_ctrl_t;

endpackage

// ===== hdl/abam_ring.sv =====
`timescale 1ns / 1ps

module abam_ring #(
    parameter int WINDOW_LENGTH = 500
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd,
    input  logic                          wr,
    input  logic                          prime,
    input  logic [abam_pkg::SAMPLE_W-1:0] sample,
    output logic [abam_pkg::SAMPLE_W-1:0] old_sample
);

    localparam int WP_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);

    logic [abam_pkg::SAMPLE_W-1:0] mem [WINDOW_LENGTH];
    logic [abam_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic [WP_W-1:0]               wp_reg, wp_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [abam_pkg::SAMPLE_W-1:0] prime_reg, prime_next;
    logic                          hit_reg, hit_next;

    // An entry that has not been overwritten since the last prime reads as the prime value.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= sample;
        end
        if (rd)
        begin
            rd_data_reg <= mem[wp_reg];
        end
    end

    always_comb
    begin
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        prime_next = prime_reg;
        hit_next   = hit_reg;
        if (rd)
        begin
            hit_next = (fill_reg == FILL_W'(WINDOW_LENGTH));
        end
        if (wr)
        begin
            if (wp_reg == WP_W'(WINDOW_LENGTH - 1))
            begin
                wp_next = '0;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
            if (fill_reg != FILL_W'(WINDOW_LENGTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (prime)
        begin
            prime_next = sample;
            fill_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            prime_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            prime_reg <= prime_next;
            hit_reg   <= hit_next;
        end
    end

    assign old_sample = hit_reg ? rd_data_reg : prime_reg;

endmodule

// ===== hdl/abam_div.sv =====
`timescale 1ns / 1ps

module abam_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [abam_pkg::DIV_W-1:0]     dividend,
    input  logic [abam_pkg::DIVISOR_W-1:0] divisor,
    output logic                           busy,
    output logic [abam_pkg::DIV_W-1:0]     quotient
);

    localparam int DW    = abam_pkg::DIV_W;
    localparam int RW    = abam_pkg::DIVISOR_W;
    localparam int STEPS = abam_pkg::DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [RW-1:0]    div_reg;

    logic [RW:0] r1, r1s, r2, r2s;
    logic        b1, b2;

    // Two restoring steps per cycle.
    always_comb
    begin
        r1  = {rem_reg, quo_reg[DW-1]};
        b1  = (r1 >= {1'b0, div_reg});
        r1s = b1 ? (r1 - {1'b0, div_reg}) : r1;
        r2  = {r1s[RW-1:0], quo_reg[DW-2]};
        b2  = (r2 >= {1'b0, div_reg});
        r2s = b2 ? (r2 - {1'b0, div_reg}) : r2;

        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(STEPS);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = r2s[RW-1:0];
            quo_next = {quo_reg[DW-3:0], b1, b2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== hdl/abam_seq.sv =====
`timescale 1ns / 1ps

module abam_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  abam_pkg::abam_status_t status,
    output abam_pkg::abam_ctrl_t   ctrl
);

    localparam int PC_W = 4;

    typedef struct packed {
        abam_pkg::uop_t  op;
        abam_pkg::cond_t cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_ACCEPT   = 4'd0;
    localparam logic [PC_W-1:0] PC_MAP_WAIT = 4'd7;
    localparam logic [PC_W-1:0] PC_FINISH   = 4'd8;
    localparam logic [PC_W-1:0] PC_PRIME    = 4'd10;

    // The operation of a step takes effect only when its jump is not taken.
    function automatic uword_t rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: abam_pkg::UOP_NOP, cond: abam_pkg::COND_ALWAYS, target: PC_ACCEPT};
        case (pc)
            4'd0:  w = '{abam_pkg::UOP_ACCEPT,   abam_pkg::COND_NO_ITEM,  PC_ACCEPT};
            4'd1:  w = '{abam_pkg::UOP_NOP,      abam_pkg::COND_PRIME,    PC_PRIME};
            4'd2:  w = '{abam_pkg::UOP_UPDATE,   abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd3:  w = '{abam_pkg::UOP_DIV_AVG,  abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd4:  w = '{abam_pkg::UOP_MV,       abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd5:  w = '{abam_pkg::UOP_MAP_PREP, abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd6:  w = '{abam_pkg::UOP_DIV_MAP,  abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd7:  w = '{abam_pkg::UOP_NOP,      abam_pkg::COND_DIV_BUSY, PC_MAP_WAIT};
            4'd8:  w = '{abam_pkg::UOP_FINISH,   abam_pkg::COND_OUT_BUSY, PC_FINISH};
            4'd9:  w = '{abam_pkg::UOP_NOP,      abam_pkg::COND_ALWAYS,   PC_ACCEPT};
            4'd10: w = '{abam_pkg::UOP_PRIME,    abam_pkg::COND_NONE,     PC_ACCEPT};
            4'd11: w = '{abam_pkg::UOP_NOP,      abam_pkg::COND_ALWAYS,   PC_ACCEPT};
            default: w = '{abam_pkg::UOP_NOP,    abam_pkg::COND_ALWAYS,   PC_ACCEPT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;
    logic            jump;

    always_comb
    begin
        uw = rom(pc_reg);
        case (uw.cond)
            abam_pkg::COND_NONE:     jump = 1'b0;
            abam_pkg::COND_ALWAYS:   jump = 1'b1;
            abam_pkg::COND_NO_ITEM:  jump = !status.item_taken;
            abam_pkg::COND_PRIME:    jump = status.prime;
            abam_pkg::COND_DIV_BUSY: jump = status.div_busy;
            abam_pkg::COND_OUT_BUSY: jump = status.out_busy;
            default:                 jump = 1'b1;
        endcase
        pc_next   = jump ? uw.target : (pc_reg + 1'b1);
        ctrl.op   = uw.op;
        ctrl.fire = !jump;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_ACCEPT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/ambient_brightness_average_map.sv =====
`timescale 1ns / 1ps

// Moving-average ambient light mapper. Each sample request replaces the oldest entry of a
// WINDOW_LENGTH deep ring, averages the window, converts the average to millivolts, maps it
// linearly from the dark..bright span onto min_output..max_output, adds base_brightness - 127
// and clamps the result; a prime request fills the whole window with its sample and returns
// nothing. A microcoded sequencer runs one request at a time. The window average comes from a
// reciprocal multiplication and the map division from a divider that retires two quotient bits
// per cycle. A sample request passes through accept, ring update, average, millivolt, map
// preparation, division and finish steps; a prime request only loads the prime value. A new
// request is taken while the previous result still waits on the output register, and a stalled
// result holds the sequencer at its finish step. No clearing pass follows reset: the ring reads
// as zero until each entry is written.
module ambient_brightness_average_map #(
    parameter int WINDOW_LENGTH = 500
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  abam_pkg::abam_req_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output abam_pkg::abam_rsp_t             rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abam_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int TOTAL_W = $clog2(((1 << abam_pkg::SAMPLE_W) - 1) * WINDOW_LENGTH + 1);
    localparam int SW      = abam_pkg::SAMPLE_W;
    localparam int DW      = abam_pkg::DIV_W;
    localparam int V_W     = DW + 3;

    // The window average is the total times a rounded-up reciprocal, shifted down.
    localparam int RECIP_W     = TOTAL_W + 1;
    localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_LENGTH);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_LENGTH) - 1)
                 / longint'(WINDOW_LENGTH));

    abam_pkg::abam_ctrl_t   ctrl;
    abam_pkg::abam_status_t status;

    logic item_taken;
    logic fire_update, fire_prime, div_start;

    abam_pkg::abam_req_t item_reg;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SW-1:0]       old_sample;

    logic [11:0] dark_reg, bright_reg;
    logic [7:0]  min_reg, max_reg, base_reg;

    logic [SW-1:0]             avg_reg;
    logic [abam_pkg::MV_W-1:0] mv_reg;
    logic [DW-1:0]             num_mag_reg;
    logic [11:0]               den_mag_reg;
    logic                      neg_reg, den_zero_reg;

    logic                      out_valid_reg;
    abam_pkg::abam_rsp_t       out_reg;

    logic                      div_busy;
    logic [DW-1:0]             quotient;

    logic [TOTAL_W+RECIP_W-1:0] avg_prod;
    logic [23:0]        mv_prod;
    logic signed [12:0] dm, den;
    logic signed [8:0]  span;
    logic signed [21:0] num;
    logic signed [DW:0] q_s;
    logic signed [V_W-1:0] v, v_lo, lo, hi, v_out;

    assign cfg_ready = 1'b1;

    assign req_stall  = (ctrl.op != abam_pkg::UOP_ACCEPT);
    assign item_taken = req_valid && !req_stall;

    assign status.item_taken = item_taken;
    assign status.prime      = (item_reg.action == abam_pkg::ACTION_PRIME);
    assign status.div_busy   = div_busy;
    assign status.out_busy   = out_valid_reg && rsp_stall;

    assign fire_update = ctrl.fire && (ctrl.op == abam_pkg::UOP_UPDATE);
    assign fire_prime  = ctrl.fire && (ctrl.op == abam_pkg::UOP_PRIME);
    assign div_start   = ctrl.fire && (ctrl.op == abam_pkg::UOP_DIV_MAP);

    abam_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    abam_ring #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (item_taken),
        .wr         (fire_update),
        .prime      (fire_prime),
        .sample     (item_reg.sample),
        .old_sample (old_sample)
    );

    abam_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag_reg),
        .divisor  (den_mag_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        total_next = total_reg;
        if (fire_update)
        begin
            total_next = total_reg - TOTAL_W'(old_sample) + TOTAL_W'(item_reg.sample);
        end
        else if (fire_prime)
        begin
            total_next = TOTAL_W'(item_reg.sample * WINDOW_LENGTH);
        end

        avg_prod = total_reg * RECIP;
        mv_prod  = avg_reg * 12'(abam_pkg::MV_FULL_SCALE);

        dm   = $signed({1'b0, mv_reg}) - $signed({1'b0, dark_reg});
        den  = $signed({1'b0, bright_reg}) - $signed({1'b0, dark_reg});
        span = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
        num  = dm * span;

        if (den_zero_reg)
        begin
            q_s = '0;
        end
        else if (neg_reg)
        begin
            q_s = -$signed({1'b0, quotient});
        end
        else
        begin
            q_s = $signed({1'b0, quotient});
        end

        lo    = $signed({{(V_W - 8){1'b0}}, min_reg});
        hi    = $signed({{(V_W - 8){1'b0}}, max_reg});
        v     = V_W'(q_s) + lo + $signed({{(V_W - 8){1'b0}}, base_reg})
                - V_W'(abam_pkg::BASE_NEUTRAL);
        v_lo  = (v < lo) ? lo : v;
        v_out = (v_lo > hi) ? hi : v_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            dark_reg      <= 12'd0;
            bright_reg    <= 12'd3300;
            min_reg       <= 8'd0;
            max_reg       <= 8'd255;
            base_reg      <= 8'd127;
        end
        else
        begin
            total_reg <= total_next;
            if (ctrl.fire && (ctrl.op == abam_pkg::UOP_FINISH))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    abam_pkg::CFG_DARK:   dark_reg   <= cfg_data;
                    abam_pkg::CFG_BRIGHT: bright_reg <= cfg_data;
                    abam_pkg::CFG_MIN:    min_reg    <= cfg_data[7:0];
                    abam_pkg::CFG_MAX:    max_reg    <= cfg_data[7:0];
                    abam_pkg::CFG_BASE:   base_reg   <= cfg_data[7:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_taken)
        begin
            item_reg <= req;
        end
        if (ctrl.fire && (ctrl.op == abam_pkg::UOP_DIV_AVG))
        begin
            avg_reg <= avg_prod[RECIP_SHIFT +: SW];
        end
        if (ctrl.fire && (ctrl.op == abam_pkg::UOP_MV))
        begin
            mv_reg <= mv_prod[23:abam_pkg::ADC_SHIFT];
        end
        if (ctrl.fire && (ctrl.op == abam_pkg::UOP_MAP_PREP))
        begin
            num_mag_reg  <= num[21] ? DW'(-num) : DW'(num);
            den_mag_reg  <= den[12] ? 12'(-den) : 12'(den);
            neg_reg      <= num[21] ^ den[12];
            den_zero_reg <= (den == '0);
        end
        if (ctrl.fire && (ctrl.op == abam_pkg::UOP_FINISH))
        begin
            out_reg.brightness <= v_out[7:0];
            out_reg.average_mv <= mv_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
